/* rtl/atdf_pkg.sv */
// ----------------------------------------------------------------------------
// atdf_pkg: shared types and constants for the attenuation-to-dac frame block
// Beat layouts, command codes between controller and datapath, fixed constants.
// ----------------------------------------------------------------------------
package atdf_pkg;

  // input beat
  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] centi_db;
    logic [15:0]        millivolts;
    logic [4:0]         entry_index;
    logic [15:0]        entry_value;
  } in_item_t;

  // result beat
  typedef struct packed {
    logic [15:0] spi_frame;
    logic [1:0]  status;
    logic [11:0] attenuation;
    logic [11:0] dac_code;
  } out_item_t;

  // command kinds
  typedef enum logic [1:0] {
    KIND_DB   = 2'd0,
    KIND_MV   = 2'd1,
    KIND_WR   = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  // result status codes
  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_RANGE = 2'd1,
    STS_MISS  = 2'd2
  } status_t;

  // fixed constants
  localparam logic [11:0] MAX_CENTI_DB = 12'd3000;
  localparam logic [15:0] MAX_MV       = 16'd3300;
  localparam logic [15:0] HALF_MV      = 16'd1650;
  localparam logic [11:0] DAC_FULL     = 12'd4095;
  localparam logic [15:0] FRAME_FLAG   = 16'h8000;
  localparam logic [6:0]  CENTI        = 7'd100;
  // divide by 100 as multiply and shift, exact for values up to 3000
  localparam logic [12:0] DIV100_MUL   = 13'd5243;
  localparam int          DIV100_SHIFT = 19;
  // divide by 100 as multiply and shift, exact below 2^23
  localparam logic [23:0] RECIP100_MUL   = 24'd10737419;
  localparam int          RECIP100_SHIFT = 30;
  // divide by 3300 as multiply and shift, exact below 2^24
  localparam logic [24:0] RECIP3300_MUL   = 25'd20824084;
  localparam int          RECIP3300_SHIFT = 36;
  // shared divider widths
  localparam int          DIV_NW       = 24;
  localparam int          DIV_DW       = 16;

  // controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_DB_IDX,
    S_DB_A,
    S_DB_B,
    S_DB_C,
    S_DB_DIV,
    S_FR_MUL,
    S_FR_DIV,
    S_FR_FIN,
    S_SR_FIRST,
    S_SR_SEG,
    S_SR_HIT,
    S_SR_DIV,
    S_DONE
  } state_t;

  // datapath operations
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_RANGE,
    OP_MISS,
    OP_WRITE,
    OP_MAG,
    OP_DB_IDX,
    OP_DB_A,
    OP_DB_B,
    OP_DB_C,
    OP_DB_V,
    OP_FR_SAT,
    OP_FR_DIV,
    OP_FR_QUO,
    OP_FR_FIN,
    OP_SR_RD0,
    OP_SR_FIRST,
    OP_SR_FIRST_HIT,
    OP_SR_STEP,
    OP_SR_EXACT,
    OP_SR_HIT,
    OP_SR_DIV,
    OP_SR_ATT
  } dp_op_t;

  // controller to datapath
  typedef struct packed {
    dp_op_t op;
    logic   out_load;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    kind_t kind;
    logic  mag_bad;
    logic  mv_bad;
    logic  wr_bad;
    logic  idx_bad;
    logic  v_big;
    logic  div_done;
    logic  val_eq;
    logic  seg_hit;
    logic  more;
  } dp_stat_t;

endpackage

/* rtl/atdf_div.sv */
// ----------------------------------------------------------------------------
// atdf_div: restoring divider for the search segment fraction
// One quotient bit per cycle; done pulses when the quotient is final.
// ----------------------------------------------------------------------------
module atdf_div
  import atdf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIV_NW-1:0] dividend,
  input  logic [DIV_DW-1:0] divisor,
  output logic              done,
  output logic [DIV_NW-1:0] quo
);

  localparam int CNTW = $clog2(DIV_NW + 1);

  logic              busy_r;
  logic              done_r;
  logic [CNTW-1:0]   cnt_r;
  logic [DIV_NW-1:0] quo_r;
  logic [DIV_DW-1:0] rem_r;
  logic [DIV_DW-1:0] dsr_r;
  logic [DIV_DW:0]   trial;
  logic              fits;

  // trial subtract of the shifted partial remainder
  assign trial = {rem_r, quo_r[DIV_NW-1]};
  assign fits  = trial >= {1'b0, dsr_r};

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == CNTW'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNTW'(DIV_NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNTW'(1);
        if (cnt_r == CNTW'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // quotient and remainder
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DIV_NW-2:0], fits};
      rem_r <= fits ? DIV_DW'(trial - {1'b0, dsr_r}) : trial[DIV_DW-1:0];
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

/* rtl/atdf_dpath.sv */
// ----------------------------------------------------------------------------
// atdf_dpath: datapath of the attenuation-to-dac frame block
// Voltage table memory, interpolation, table search, dac code and frame state.
// ----------------------------------------------------------------------------
module atdf_dpath
  import atdf_pkg::*;
#(
  parameter int TABLE_ENTRIES = 31
) (
  input  logic      clk,
  input  logic      rst_n,
  input  dp_cmd_t   cmd,
  input  in_item_t  in_data,
  output dp_stat_t  stat,
  output out_item_t out_data
);

  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam int CW = IW + 2;

  // saturate a searched attenuation to 12 bits
  function automatic logic [11:0] sat_att(input logic [14:0] v);
    sat_att = (v > 15'(DAC_FULL)) ? DAC_FULL : v[11:0];
  endfunction

  in_item_t          in_r;
  logic [11:0]       mag_r;
  logic [IW-1:0]     idx_r;
  logic [6:0]        frac_r;
  logic [15:0]       a_r;
  logic [15:0]       b_r;
  logic [22:0]       p_r;
  logic [22:0]       num_r;
  logic [15:0]       v_r;
  logic [23:0]       prod_r;
  logic [11:0]       fr_quo_r;
  logic [IW-1:0]     srch_r;
  logic [15:0]       d_r;
  logic [15:0]       span_r;
  logic [11:0]       pend_att_r;
  status_t           status_r;
  logic [15:0]       frame_r;
  logic [11:0]       att_r;
  out_item_t         out_r;

  logic [15:0]       mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] vld_r;
  logic [15:0]       rdata_r;
  logic [15:0]       rinit_r;
  logic              rvld_r;
  logic [IW-1:0]     raddr;
  logic [IW-1:0]     waddr;
  logic [15:0]       tval;

  logic [16:0]       mag_c;
  logic [24:0]       prod_c;
  logic [4:0]        idx_c;
  logic [6:0]        frac_c;
  logic [15:0]       mv;
  logic              a_lt_b;
  logic [15:0]       seg_d;
  logic [15:0]       seg_span;
  logic [CW-1:0]     srch_p2;
  logic [14:0]       exact_c;
  logic [14:0]       seg_att_c;
  logic [46:0]       q100_c;
  logic [48:0]       q3300_c;
  logic [15:0]       rem_c;
  logic              round_up;
  logic [12:0]       code_sum;
  logic [11:0]       code_c;

  logic              div_start;
  logic [DIV_NW-1:0] div_n;
  logic [DIV_DW-1:0] div_d;
  logic              div_done;
  logic [DIV_NW-1:0] div_q;

  assign mv = in_r.millivolts;

  // table value: written entries from memory, others read as 100 * index
  assign tval = rvld_r ? rdata_r : rinit_r;

  // magnitude of the dB request
  assign mag_c = in_r.centi_db[15] ? (17'h10000 - {1'b0, in_r.centi_db})
                                   : {1'b0, in_r.centi_db};

  // whole dB and hundredths
  assign prod_c = 25'(mag_r) * 25'(DIV100_MUL);
  assign idx_c  = 5'(prod_c >> DIV100_SHIFT);
  assign frac_c = 7'(mag_r - 12'(idx_c) * 12'(CENTI));

  // segment between T[i] in a_r and T[i+1] read back
  assign a_lt_b   = a_r < tval;
  assign seg_d    = a_lt_b ? (mv - a_r) : (a_r - mv);
  assign seg_span = a_lt_b ? (tval - a_r) : (a_r - tval);
  assign srch_p2  = CW'(srch_r) + CW'(2);
  assign exact_c  = 15'(CW'(srch_r) + CW'(1)) * 15'(CENTI);
  assign seg_att_c = 15'(srch_r) * 15'(CENTI) + 15'(div_q[6:0]);

  // interpolated voltage: weighted sum divided by 100
  assign q100_c = 47'(num_r) * 47'(RECIP100_MUL);

  // dac code: v * 4095 / 3300, rounding above half only
  assign q3300_c  = 49'(prod_r) * 49'(RECIP3300_MUL);
  assign rem_c    = 16'(prod_r - 24'(fr_quo_r) * 24'(MAX_MV));
  assign round_up = rem_c > HALF_MV;
  assign code_sum = 13'(fr_quo_r) + 13'(round_up);
  assign code_c   = (code_sum > 13'(DAC_FULL)) ? DAC_FULL : code_sum[11:0];

  // status toward the controller
  always_comb begin
    stat.kind     = kind_t'(in_r.kind);
    stat.mag_bad  = mag_c > 17'(MAX_CENTI_DB);
    stat.mv_bad   = mv > MAX_MV;
    stat.wr_bad   = 32'(in_r.entry_index) >= 32'(TABLE_ENTRIES);
    stat.idx_bad  = (32'(idx_c) >= 32'(TABLE_ENTRIES)) ||
                    ((frac_c != '0) && (32'(idx_c) + 32'd1 >= 32'(TABLE_ENTRIES)));
    stat.v_big    = v_r > MAX_MV;
    stat.div_done = div_done;
    stat.val_eq   = tval == mv;
    stat.seg_hit  = a_lt_b ? ((a_r < mv) && (mv < tval))
                           : ((tval < mv) && (mv < a_r));
    stat.more     = 32'(srch_p2) < 32'(TABLE_ENTRIES);
  end

  // read address per operation
  always_comb begin
    case (cmd.op)
      OP_DB_IDX:   raddr = IW'(idx_c);
      OP_DB_A:     raddr = (frac_r != '0) ? (idx_r + IW'(1)) : idx_r;
      OP_SR_FIRST: raddr = IW'(1);
      OP_SR_STEP:  raddr = srch_p2[IW-1:0];
      default:     raddr = '0;
    endcase
  end

  assign waddr = IW'(in_r.entry_index);

  // table memory with registered read
  always_ff @(posedge clk) begin
    if (cmd.op == OP_WRITE) begin
      mem[waddr] <= in_r.entry_value;
    end
    rdata_r <= mem[raddr];
    rinit_r <= 16'(raddr) * 16'(CENTI);
    rvld_r  <= vld_r[raddr];
  end

  // written-entry flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (cmd.op == OP_WRITE) begin
      vld_r[waddr] <= 1'b1;
    end
  end

  // divider operands
  always_comb begin
    div_start = 1'b0;
    div_n     = '0;
    div_d     = '0;
    case (cmd.op)
      OP_SR_DIV: begin
        div_start = 1'b1;
        div_n     = DIV_NW'(d_r) * DIV_NW'(CENTI);
        div_d     = span_r;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  atdf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .done     (div_done),
    .quo      (div_q)
  );

  // working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD:   in_r <= in_data;
      OP_RANGE:  status_r <= STS_RANGE;
      OP_MISS:   status_r <= STS_MISS;
      OP_WRITE:  status_r <= STS_OK;
      OP_MAG:    mag_r <= mag_c[11:0];
      OP_DB_IDX: begin
        idx_r  <= IW'(idx_c);
        frac_r <= frac_c;
      end
      OP_DB_A:   a_r <= tval;
      OP_DB_B: begin
        p_r <= 23'(a_r) * 23'(CENTI - frac_r);
        b_r <= tval;
      end
      OP_DB_C: begin
        num_r      <= p_r + 23'(b_r) * 23'(frac_r);
        pend_att_r <= mag_r;
      end
      OP_DB_V:   v_r <= q100_c[RECIP100_SHIFT +: 16];
      OP_FR_SAT: status_r <= STS_OK;
      OP_FR_DIV: prod_r <= 24'(v_r) * 24'(DAC_FULL);
      OP_FR_QUO: fr_quo_r <= q3300_c[RECIP3300_SHIFT +: 12];
      OP_FR_FIN: status_r <= STS_OK;
      OP_SR_FIRST: begin
        a_r    <= tval;
        srch_r <= '0;
      end
      OP_SR_FIRST_HIT: begin
        pend_att_r <= '0;
        v_r        <= mv;
      end
      OP_SR_STEP: begin
        a_r    <= tval;
        srch_r <= srch_r + IW'(1);
      end
      OP_SR_EXACT: begin
        pend_att_r <= sat_att(exact_c);
        v_r        <= mv;
      end
      OP_SR_HIT: begin
        d_r    <= seg_d;
        span_r <= seg_span;
      end
      OP_SR_ATT: begin
        pend_att_r <= sat_att(seg_att_c);
        v_r        <= mv;
      end
      default: begin
      end
    endcase
  end

  // frame and attenuation, committed on success
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_r <= '0;
      att_r   <= '0;
    end else if (cmd.op == OP_FR_SAT) begin
      frame_r <= FRAME_FLAG | 16'(DAC_FULL);
      att_r   <= pend_att_r;
    end else if (cmd.op == OP_FR_FIN) begin
      frame_r <= FRAME_FLAG | 16'(code_c);
      att_r   <= pend_att_r;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r.spi_frame   <= frame_r;
      out_r.status      <= status_r;
      out_r.attenuation <= att_r;
      out_r.dac_code    <= frame_r[11:0];
    end
  end

  assign out_data = out_r;

endmodule

/* rtl/atdf_ctrl.sv */
// ----------------------------------------------------------------------------
// atdf_ctrl: controller of the attenuation-to-dac frame block
// Sequences one command through decode, table reads, divides and the result.
// ----------------------------------------------------------------------------
module atdf_ctrl
  import atdf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || !out_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        case (stat.kind)
          KIND_DB: state_nxt = stat.mag_bad ? S_DONE : S_DB_IDX;
          KIND_MV: state_nxt = stat.mv_bad ? S_DONE : S_SR_FIRST;
          default: state_nxt = S_DONE;
        endcase
      end
      S_DB_IDX:   state_nxt = stat.idx_bad ? S_DONE : S_DB_A;
      S_DB_A:     state_nxt = S_DB_B;
      S_DB_B:     state_nxt = S_DB_C;
      S_DB_C:     state_nxt = S_DB_DIV;
      S_DB_DIV:   state_nxt = S_FR_MUL;
      S_FR_MUL:   state_nxt = stat.v_big ? S_DONE : S_FR_DIV;
      S_FR_DIV:   state_nxt = S_FR_FIN;
      S_FR_FIN:   state_nxt = S_DONE;
      S_SR_FIRST: state_nxt = stat.val_eq ? S_FR_MUL : S_SR_SEG;
      S_SR_SEG: begin
        if (stat.seg_hit) begin
          state_nxt = S_SR_HIT;
        end else if (stat.val_eq) begin
          state_nxt = S_FR_MUL;
        end else if (!stat.more) begin
          state_nxt = S_DONE;
        end
      end
      S_SR_HIT:   state_nxt = S_SR_DIV;
      S_SR_DIV: begin
        if (stat.div_done) state_nxt = S_FR_MUL;
      end
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default:    state_nxt = S_IDLE;
    endcase
  end

  // outputs and datapath commands
  always_comb begin
    cmd.op       = OP_NONE;
    cmd.out_load = 1'b0;
    in_stall     = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) cmd.op = OP_LOAD;
      end
      S_DECODE: begin
        case (stat.kind)
          KIND_DB: cmd.op = stat.mag_bad ? OP_RANGE : OP_MAG;
          KIND_MV: cmd.op = stat.mv_bad ? OP_RANGE : OP_SR_RD0;
          KIND_WR: cmd.op = stat.wr_bad ? OP_RANGE : OP_WRITE;
          default: cmd.op = OP_RANGE;
        endcase
      end
      S_DB_IDX:   cmd.op = stat.idx_bad ? OP_RANGE : OP_DB_IDX;
      S_DB_A:     cmd.op = OP_DB_A;
      S_DB_B:     cmd.op = OP_DB_B;
      S_DB_C:     cmd.op = OP_DB_C;
      S_DB_DIV:   cmd.op = OP_DB_V;
      S_FR_MUL:   cmd.op = stat.v_big ? OP_FR_SAT : OP_FR_DIV;
      S_FR_DIV:   cmd.op = OP_FR_QUO;
      S_FR_FIN:   cmd.op = OP_FR_FIN;
      S_SR_FIRST: cmd.op = stat.val_eq ? OP_SR_FIRST_HIT : OP_SR_FIRST;
      S_SR_SEG: begin
        if (stat.seg_hit) begin
          cmd.op = OP_SR_HIT;
        end else if (stat.val_eq) begin
          cmd.op = OP_SR_EXACT;
        end else if (stat.more) begin
          cmd.op = OP_SR_STEP;
        end else begin
          cmd.op = OP_MISS;
        end
      end
      S_SR_HIT:   cmd.op = OP_SR_DIV;
      S_SR_DIV: begin
        if (stat.div_done) cmd.op = OP_SR_ATT;
      end
      S_DONE: begin
        if (out_free) cmd.out_load = 1'b1;
      end
      default: begin
        cmd.op = OP_NONE;
      end
    endcase
    out_valid_nxt = cmd.out_load || (out_valid_r && out_stall);
  end

  // state and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* rtl/attenuation_to_dac_frame.sv */
// ----------------------------------------------------------------------------
// attenuation_to_dac_frame: attenuator control voltage to 16-bit dac frame
// dB commands interpolate the voltage table, mV commands search it; either
// way the voltage becomes a rounded, saturated 12-bit code in the frame.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            beat
//  in_       in         in_valid / in_stall   in_item_t: command and operands
//  out_      out        out_valid / out_stall out_item_t: frame, status, att, code
//
//  one command at a time; the result is valid when the result register loads,
//  and the next command is taken in the cycle after that load
//  table write or rejected command: decode, then the result (a dB index past
//  the table is rejected in the index state); dB command: index, table reads,
//  weighted sum, divide by 100, dac code, saturated at once above full scale;
//  mV command: an exact hit, a segment hit and 24-step divide, or a miss
//  reset clears frame, attenuation and the written-entry flags; unwritten
//  entries read as 100 * index, so no clearing pass is needed
//  a stalled result keeps the next finished command waiting in the controller
module attenuation_to_dac_frame
  import atdf_pkg::*;
#(
  parameter int TABLE_ENTRIES = 31
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer
  atdf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // table, arithmetic and state
  atdf_dpath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule

/* sim/attenuation_to_dac_frame_tb.sv */
// ----------------------------------------------------------------------------
// attenuation_to_dac_frame_tb: self-checking bench for the attenuation block
// A short table of directed commands covers the range limits, table misses,
// rounding at exactly one half and descending or flat table segments. Random
// commands follow, mixed with whole-table reloads so that the mV search finds
// hits. Each result beat is compared field by field with its typed-in or predicted
// result, and the input idles and the result side stalls in random bursts.
// ----------------------------------------------------------------------------
module attenuation_to_dac_frame_tb;
  import atdf_pkg::*;

  localparam int          TABLE_ENTRIES = 31;
  localparam int          RANDOM_ITEMS  = 1300;
  localparam int          QUIET_ITEMS   = 150;
  localparam int          DRAIN_CYCLES  = 120;
  localparam int unsigned CYCLE_LIMIT   = 800000;

  // one directed command, with its result typed in where it is plain to see
  typedef struct {
    in_item_t  cmd;
    bit        typed;
    out_item_t result;
  } step_row_t;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  // predictor state
  logic [15:0] volt_tbl [TABLE_ENTRIES];
  logic [15:0] frame_q;
  logic [11:0] atten_q;

  out_item_t   pending_frames[$];
  in_item_t    cmd_backlog[$];
  step_row_t   directed_steps[$];

  int unsigned cycle_cnt  = 0;
  int          n_errors   = 0;
  bit          quiet      = 1'b0;
  bit          idle_on    = 1'b1;
  bit          stall_on   = 1'b1;
  int          stall_left = 0;

  attenuation_to_dac_frame #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #1 clk = ~clk;

  // mV to frame: scale to 12 bits, round up only above one half, saturate
  function automatic logic [15:0] mv_to_frame(input int unsigned mv);
    int unsigned prod;
    int unsigned code;
    prod = mv * DAC_FULL;
    code = prod / MAX_MV;
    if (2 * (prod % MAX_MV) > MAX_MV) code++;
    if (code > DAC_FULL) code = DAC_FULL;
    return FRAME_FLAG | 16'(code);
  endfunction

  // applies one command to the predictor state and returns its result beat
  function automatic out_item_t frame_after_command(input in_item_t c);
    out_item_t   r;
    status_t     sts;
    logic [15:0] raw;
    int unsigned mag, idx, frac, num, mv, a, b, att, i;
    bit          hit;
    sts = STS_RANGE;
    case (kind_t'(c.kind))
      KIND_DB: begin
        // sign dropped, then interpolate between neighboring whole-dB entries
        raw  = c.centi_db;
        mag  = raw[15] ? 32'h10000 - raw : raw;
        idx  = mag / CENTI;
        frac = mag % CENTI;
        if (mag <= MAX_CENTI_DB && idx < TABLE_ENTRIES &&
            (frac == 0 || idx + 1 < TABLE_ENTRIES)) begin
          num = volt_tbl[idx] * CENTI;
          if (frac != 0)
            num = volt_tbl[idx] * (CENTI - frac) + volt_tbl[idx + 1] * frac;
          atten_q = 12'(mag);
          frame_q = mv_to_frame(num / CENTI);
          sts     = STS_OK;
        end
      end
      KIND_MV: begin
        // first exact entry or enclosing segment from index 0 upward wins
        mv = c.millivolts;
        if (mv <= MAX_MV) begin
          hit = 1'b0;
          att = 0;
          for (i = 0; i < TABLE_ENTRIES && !hit; i++) begin
            a = volt_tbl[i];
            if (a == mv) begin
              att = i * CENTI;
              hit = 1'b1;
            end else if (i + 1 < TABLE_ENTRIES) begin
              b = volt_tbl[i + 1];
              if (a < b) begin
                if (a < mv && mv < b) begin
                  att = i * CENTI + (mv - a) * CENTI / (b - a);
                  hit = 1'b1;
                end
              end else if (b < mv && mv < a) begin
                att = i * CENTI + (a - mv) * CENTI / (a - b);
                hit = 1'b1;
              end
            end
          end
          if (!hit) begin
            sts = STS_MISS;
          end else begin
            if (att > DAC_FULL) att = DAC_FULL;
            atten_q = 12'(att);
            frame_q = mv_to_frame(mv);
            sts     = STS_OK;
          end
        end
      end
      KIND_WR: begin
        if (c.entry_index < TABLE_ENTRIES) begin
          volt_tbl[c.entry_index] = c.entry_value;
          sts = STS_OK;
        end
      end
      default: ;
    endcase
    r.spi_frame   = frame_q;
    r.status      = sts;
    r.attenuation = atten_q;
    r.dac_code    = frame_q[11:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic void add_step(input kind_t k, input int db, input int mv,
                                   input int idx, input int val, input bit typed,
                                   input status_t sts, input logic [15:0] frame,
                                   input logic [11:0] att);
    step_row_t row;
    row.cmd.kind         = k;
    row.cmd.centi_db     = 16'(db);
    row.cmd.millivolts   = 16'(mv);
    row.cmd.entry_index  = 5'(idx);
    row.cmd.entry_value  = 16'(val);
    row.typed            = typed;
    row.result.spi_frame   = frame;
    row.result.status      = sts;
    row.result.attenuation = att;
    row.result.dac_code    = frame[11:0];
    directed_steps.push_back(row);
  endfunction

  // every field random, kind included
  function automatic in_item_t scrambled_command();
    in_item_t c;
    c.kind        = 2'($urandom);
    c.centi_db    = 16'($urandom);
    c.millivolts  = 16'($urandom);
    c.entry_index = 5'($urandom);
    c.entry_value = 16'($urandom);
    return c;
  endfunction

  function automatic in_item_t random_command();
    in_item_t c;
    int       pick, db, k;
    c    = scrambled_command();
    pick = $urandom_range(0, 99);
    if (pick < 38) begin
      c.kind = KIND_DB;
      if ($urandom_range(0, 7) != 0) begin
        db = ($urandom_range(0, 3) == 0) ? 100 * $urandom_range(0, 30)
                                         : $urandom_range(0, 3000);
        c.centi_db = $urandom_range(0, 1) ? 16'(-db) : 16'(db);
      end
    end else if (pick < 78) begin
      // aim at table entries and their neighbors as well as anywhere in range
      c.kind = KIND_MV;
      k = $urandom_range(0, TABLE_ENTRIES - 1);
      case ($urandom_range(0, 5))
        0, 1:    c.millivolts = 16'($urandom_range(0, 3300));
        2:       c.millivolts = volt_tbl[k];
        3:       c.millivolts = volt_tbl[k] + 16'd1;
        4:       c.millivolts = volt_tbl[k] - 16'd1;
        default: ;
      endcase
    end else if (pick < 96) begin
      c.kind = KIND_WR;
      c.entry_index = ($urandom_range(0, 15) == 0) ? 5'd31
                                                   : 5'($urandom_range(0, TABLE_ENTRIES - 1));
      if ($urandom_range(0, 3) != 0) c.entry_value = 16'($urandom_range(0, 3300));
    end else begin
      c.kind = KIND_NONE;
    end
    return c;
  endfunction

  // rewrite the whole table as a rising, falling or flat ramp with some noise
  function automatic void queue_table_load();
    in_item_t w;
    int       base, slope, v;
    bit       rising;
    base   = $urandom_range(0, 3300);
    slope  = $urandom_range(0, 110);
    rising = $urandom_range(0, 1);
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      v = rising ? base + i * slope : base - i * slope;
      if (v < 0) v = 0;
      w             = scrambled_command();
      w.kind        = KIND_WR;
      w.entry_index = 5'(i);
      w.entry_value = ($urandom_range(0, 11) == 0) ? 16'($urandom) : 16'(v);
      cmd_backlog.push_back(w);
    end
  endfunction

  // input idle burst length, with stretches where idling is switched off
  function automatic int next_gap();
    if ($urandom_range(0, 39) == 0) idle_on = !idle_on;
    if (quiet || !idle_on || $urandom_range(0, 2) != 0) return 0;
    return $urandom_range(1, 14);
  endfunction

  // drive one command beat, wait for it to be taken, predict its result
  task automatic send_command(input in_item_t cmd, input int gap,
                              output out_item_t predicted);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= cmd;
    do @(posedge clk); while (in_stall);
    predicted = frame_after_command(cmd);
  endtask

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_cnt, what);
    n_errors++;
  endtask

  task automatic check_frame(input out_item_t got);
    out_item_t want;
    if (pending_frames.size() == 0) begin
      report_mismatch($sformatf("result beat with nothing expected, frame %h",
                                got.spi_frame));
      return;
    end
    want = pending_frames.pop_front();
    if (got.spi_frame !== want.spi_frame)
      report_mismatch($sformatf("spi_frame %h, expected %h", got.spi_frame, want.spi_frame));
    if (got.status !== want.status)
      report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
    if (got.attenuation !== want.attenuation)
      report_mismatch($sformatf("attenuation %0d, expected %0d",
                                got.attenuation, want.attenuation));
    if (got.dac_code !== want.dac_code)
      report_mismatch($sformatf("dac_code %0d, expected %0d", got.dac_code, want.dac_code));
  endtask

  // result side: take beats, stall in random bursts
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_frame(out_data);
    if ($urandom_range(0, 199) == 0) stall_on <= !stall_on;
    if (quiet) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (stall_on && $urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 13);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    out_item_t predicted;
    int        n_sent;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;

    // predictor reset
    for (int i = 0; i < TABLE_ENTRIES; i++) volt_tbl[i] = 16'(i * CENTI);
    frame_q = '0;
    atten_q = '0;

    //        kind       dB      mV     idx val    typed status     frame     att
    add_step(KIND_DB,        0,     0,  0, 0,     1, STS_OK,    16'h8000, 12'd0);
    add_step(KIND_DB,     3000,     0,  0, 0,     1, STS_OK,    16'h8E8B, 12'd3000);
    add_step(KIND_DB,     3001,     0,  0, 0,     1, STS_RANGE, 16'h8E8B, 12'd3000);
    add_step(KIND_DB,   -32768,     0,  0, 0,     1, STS_RANGE, 16'h8E8B, 12'd3000);
    add_step(KIND_MV,        0,  3301,  0, 0,     1, STS_RANGE, 16'h8E8B, 12'd3000);
    add_step(KIND_MV,        0, 65535,  0, 0,     1, STS_RANGE, 16'h8E8B, 12'd3000);
    add_step(KIND_MV,        0,  3300,  0, 0,     1, STS_MISS,  16'h8E8B, 12'd3000);
    add_step(KIND_NONE,      0,     0,  0, 0,     1, STS_RANGE, 16'h8E8B, 12'd3000);
    add_step(KIND_WR,        0,     0, 31, 65535, 1, STS_RANGE, 16'h8E8B, 12'd3000);
    add_step(KIND_DB,    -3000,     0,  0, 0,     0, STS_OK,    16'h0000, 12'd0);
    add_step(KIND_DB,    32767,     0,  0, 0,     0, STS_OK,    16'h0000, 12'd0);
    add_step(KIND_DB,     1234,     0,  0, 0,     0, STS_OK,    16'h0000, 12'd0);
    add_step(KIND_DB,       -1,     0,  0, 0,     0, STS_OK,    16'h0000, 12'd0);
    add_step(KIND_MV,        0,     0,  0, 0,     1, STS_OK,    16'h8000, 12'd0);
    // remainder of exactly one half is not rounded up
    add_step(KIND_MV,        0,  1650,  0, 0,     1, STS_OK,    16'h87FF, 12'd1650);
    add_step(KIND_WR,        0,     0,  0, 3300,  1, STS_OK,    16'h87FF, 12'd1650);
    add_step(KIND_DB,        0,     0,  0, 0,     0, STS_OK,    16'h0000, 12'd0);
    // oversized entry drives the code into saturation
    add_step(KIND_WR,        0,     0, 30, 65535, 0, STS_OK,    16'h0000, 12'd0);
    add_step(KIND_DB,     3000,     0,  0, 0,     0, STS_OK,    16'h0000, 12'd0);
    add_step(KIND_DB,     2950,     0,  0, 0,     0, STS_OK,    16'h0000, 12'd0);
    // descending first segment, then a flat one that must never hit
    add_step(KIND_WR,        0,     0,  1, 0,     0, STS_OK,    16'h0000, 12'd0);
    add_step(KIND_MV,        0,  1000,  0, 0,     0, STS_OK,    16'h0000, 12'd0);
    add_step(KIND_WR,        0,     0,  2, 0,     0, STS_OK,    16'h0000, 12'd0);
    add_step(KIND_MV,        0,     0,  0, 0,     0, STS_OK,    16'h0000, 12'd0);
    add_step(KIND_MV,        0,  3300,  0, 0,     0, STS_OK,    16'h0000, 12'd0);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed commands
    foreach (directed_steps[k]) begin
      send_command(directed_steps[k].cmd, next_gap(), predicted);
      pending_frames.push_back(directed_steps[k].typed ? directed_steps[k].result
                                                       : predicted);
    end

    // random commands with occasional whole-table reloads
    n_sent = 0;
    while (n_sent < RANDOM_ITEMS) begin
      if (cmd_backlog.size() == 0) begin
        if ($urandom_range(0, 99) == 0) queue_table_load();
        else cmd_backlog.push_back(random_command());
      end
      if (n_sent >= RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
      send_command(cmd_backlog.pop_front(), next_gap(), predicted);
      pending_frames.push_back(predicted);
      n_sent++;
    end
    in_valid <= 1'b0;

    // drain
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
